// ===== rtl/aipr_pkg.sv =====
// Shared types, codes and constants of the ASCII integer parser with range check.
// No dependencies; every other file of the block imports this package.
package aipr_pkg;

  localparam int unsigned VALUE_W = 64;
  localparam int unsigned COUNT_W = 5;
  localparam int unsigned CHAR_W = 8;
  localparam int unsigned CFG_IDX_W = 2;

  // Parse modes as written to the mode register.
  localparam logic [1:0] MODE_UDEC = 2'd0;
  localparam logic [1:0] MODE_SDEC = 2'd1;
  localparam logic [1:0] MODE_HEX = 2'd2;
  localparam logic [1:0] MODE_SPARE = 2'd3;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_MODE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_VALUE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_VALUE = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_LENGTH = 2'd3;

  localparam logic [CHAR_W-1:0] CHAR_ZERO = 8'h30;
  localparam logic [CHAR_W-1:0] CHAR_NINE = 8'h39;
  localparam logic [CHAR_W-1:0] CHAR_LOWER_A = 8'h61;
  localparam logic [CHAR_W-1:0] CHAR_LOWER_F = 8'h66;
  localparam logic [CHAR_W-1:0] CHAR_UPPER_A = 8'h41;
  localparam logic [CHAR_W-1:0] CHAR_UPPER_F = 8'h46;
  localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2d;

  localparam logic [COUNT_W-1:0] HEX_CAP = 5'd16;
  localparam logic [COUNT_W-1:0] COUNT_MAX = 5'd31;
  localparam logic [COUNT_W-1:0] LENGTH_RESET = 5'd20;
  localparam logic [VALUE_W-1:0] SIGN_BIT = {1'b1, {(VALUE_W-1){1'b0}}};

  typedef struct packed {
    logic [VALUE_W-1:0] acc;
    logic [COUNT_W-1:0] count;
    logic               neg;
    logic               failed;
    logic               at_start;
  } parse_state_t;

  localparam parse_state_t PARSE_RESET = '{
    acc: '0, count: '0, neg: 1'b0, failed: 1'b0, at_start: 1'b1
  };

  // What a finished number hands to the range check.
  typedef struct packed {
    logic [VALUE_W-1:0] acc;
    logic               has_digits;
    logic               neg;
    logic               failed;
    logic [1:0]         mode;
  } parse_summary_t;

  typedef struct packed {
    logic       ok;
    logic [3:0] value;
  } digit_t;

  // The spare mode code behaves as unsigned decimal.
  function automatic logic [1:0] norm_mode(input logic [1:0] m);
    norm_mode = (m == MODE_SPARE) ? MODE_UDEC : m;
  endfunction

  function automatic digit_t decode_digit(input logic [CHAR_W-1:0] c, input logic hex);
    digit_t d;
    d.ok = 1'b0;
    d.value = 4'd0;
    if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
      d.ok = 1'b1;
      d.value = 4'(c - CHAR_ZERO);
    end else if (hex && c >= CHAR_LOWER_A && c <= CHAR_LOWER_F) begin
      d.ok = 1'b1;
      d.value = 4'(c - CHAR_LOWER_A + 8'd10);
    end else if (hex && c >= CHAR_UPPER_A && c <= CHAR_UPPER_F) begin
      d.ok = 1'b1;
      d.value = 4'(c - CHAR_UPPER_A + 8'd10);
    end
    decode_digit = d;
  endfunction

endpackage

// ===== rtl/aipr_ifs.sv =====
// Handshake interfaces of the parser: character input, result output, configuration writes.
// Depends on aipr_pkg for field widths.
interface aipr_char_if;
  import aipr_pkg::*;
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] char_code;
  logic              last_char;
  modport source(output valid, output char_code, output last_char, input ready);
  modport sink(input valid, input char_code, input last_char, output ready);
endinterface

interface aipr_result_if;
  import aipr_pkg::*;
  logic               valid;
  logic               ready;
  logic [VALUE_W-1:0] number;
  logic               status;
  modport source(output valid, output number, output status, input ready);
  modport sink(input valid, input number, input status, output ready);
endinterface

interface aipr_cfg_if;
  import aipr_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] reg_index;
  logic [VALUE_W-1:0]   data;
  modport source(output valid, output reg_index, output data, input ready);
  modport sink(input valid, input reg_index, input data, output ready);
endinterface

// ===== rtl/ascii_integer_parser_range_check_unit.sv =====
// Top level of the ASCII integer parser with range check: registers, pipeline, handshakes.
// Depends on aipr_pkg, aipr_ifs, aipr_step and aipr_check.
//
//  channel  direction  payload                       transaction
//  chars    sink       char_code[7:0], last_char     valid && ready
//  result   source     number[63:0], status          valid && ready
//  cfg      sink       reg_index[1:0], data[63:0]    valid && ready (ready always high)
//
// One character per cycle sustained while the result side takes results; a final character
// passes through the check register (step result) and then the result register (checked
// value). The parse state updates in a single pass, which allows that rate.
// Synchronous active-high reset clears pipeline and parse state, presets the config regs.
// A stalled result holds the result register, then the check stage, then the input
// register; characters that are not final still drain into the parse state.
module ascii_integer_parser_range_check_unit (
  input logic clk,
  input logic rst,
  aipr_char_if.sink   chars,
  aipr_result_if.source result,
  aipr_cfg_if.sink    cfg
);
  import aipr_pkg::*;

  logic [1:0]         mode;
  logic [VALUE_W-1:0] min_value;
  logic [VALUE_W-1:0] max_value;
  logic [COUNT_W-1:0] max_length;

  logic              s1_valid;
  logic [CHAR_W-1:0] s1_char;
  logic              s1_last;
  logic              s1_adv;

  parse_state_t   state;
  parse_state_t   state_next;
  logic [1:0]     eff_mode;

  logic           s2_valid;
  parse_summary_t s2_sum;
  logic           s2_free;
  logic           out_free;

  logic [VALUE_W-1:0] chk_number;
  logic               chk_status;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= MODE_UDEC;
      min_value <= '0;
      max_value <= '1;
      max_length <= LENGTH_RESET;
    end else if (cfg.valid) begin
      unique case (cfg.reg_index)
        REG_MODE:       mode <= cfg.data[1:0];
        REG_MIN_VALUE:  min_value <= cfg.data;
        REG_MAX_VALUE:  max_value <= cfg.data;
        REG_MAX_LENGTH: max_length <= cfg.data[COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  assign out_free = !result.valid || result.ready;
  assign s2_free = !s2_valid || out_free;
  // Only a final character needs room downstream.
  assign s1_adv = s1_valid && (!s1_last || s2_free);
  assign chars.ready = !s1_valid || s1_adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (chars.ready) begin
      s1_valid <= chars.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (chars.ready && chars.valid) begin
      s1_char <= chars.char_code;
      s1_last <= chars.last_char;
    end
  end

  assign eff_mode = norm_mode(mode);

  aipr_step u_step (
    .cur        (state),
    .char_code  (s1_char),
    .mode       (eff_mode),
    .max_length (max_length),
    .nxt        (state_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= PARSE_RESET;
    end else if (s1_adv) begin
      state <= s1_last ? PARSE_RESET : state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (s2_free) begin
      s2_valid <= s1_adv && s1_last;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_free && s1_adv && s1_last) begin
      s2_sum.acc <= state_next.acc;
      s2_sum.has_digits <= (state_next.count != '0);
      s2_sum.neg <= state_next.neg;
      s2_sum.failed <= state_next.failed;
      s2_sum.mode <= eff_mode;
    end
  end

  aipr_check u_check (
    .sum       (s2_sum),
    .min_value (min_value),
    .max_value (max_value),
    .number    (chk_number),
    .status    (chk_status)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (out_free) begin
      result.valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && s2_valid) begin
      result.number <= chk_number;
      result.status <= chk_status;
    end
  end

  a_restart: assert property (@(posedge clk) disable iff (rst)
    s1_adv && s1_last |=> state.at_start)
    else $error("parse state not cleared after a final character");

  a_clean_start: assert property (@(posedge clk) disable iff (rst)
    state.at_start |-> (state.acc == '0 && state.count == '0 && !state.failed && !state.neg))
    else $error("parse state at start is not clean");

  a_error_zero: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.status |-> result.number == '0)
    else $error("error result carries a nonzero number");

  a_check_hold: assert property (@(posedge clk) disable iff (rst)
    s2_valid && !out_free |=> s2_valid && $stable(s2_sum))
    else $error("check stage changed while the result was stalled");

endmodule

// ===== rtl/aipr_step.sv =====
// One character step of the parser: sign, digit decode, length cap and overflow.
// Depends on aipr_pkg.
module aipr_step (
  input  aipr_pkg::parse_state_t        cur,
  input  logic [aipr_pkg::CHAR_W-1:0]   char_code,
  input  logic [1:0]                    mode,
  input  logic [aipr_pkg::COUNT_W-1:0]  max_length,
  output aipr_pkg::parse_state_t        nxt
);
  import aipr_pkg::*;

  logic               hex;
  digit_t             dig;
  logic [COUNT_W-1:0] cap;
  logic [COUNT_W-1:0] count_inc;
  logic [VALUE_W+3:0] dec_wide;

  assign hex = (mode == MODE_HEX);
  assign dig = decode_digit(char_code, hex);
  assign cap = (hex && max_length > HEX_CAP) ? HEX_CAP : max_length;
  assign count_inc = (cur.count < COUNT_MAX) ? cur.count + 5'd1 : cur.count;
  // acc * 10 + d as acc * 8 + acc * 2 + d; anything above bit 63 is overflow.
  assign dec_wide = {1'b0, cur.acc, 3'b000} + {3'b000, cur.acc, 1'b0}
                  + {{VALUE_W{1'b0}}, dig.value};

  always_comb begin
    nxt = cur;
    nxt.at_start = 1'b0;
    if (!cur.failed) begin
      if (cur.at_start && mode == MODE_SDEC && char_code == CHAR_MINUS) begin
        nxt.neg = 1'b1;
      end else if (!dig.ok) begin
        nxt.failed = 1'b1;
      end else begin
        nxt.count = count_inc;
        if (count_inc > cap) begin
          nxt.failed = 1'b1;
        end else if (hex) begin
          if (cur.acc[VALUE_W-1:VALUE_W-4] != 4'd0) begin
            nxt.failed = 1'b1;
          end else begin
            nxt.acc = {cur.acc[VALUE_W-5:0], dig.value};
          end
        end else begin
          if (dec_wide[VALUE_W+3:VALUE_W] != 4'd0) begin
            nxt.failed = 1'b1;
          end else begin
            nxt.acc = dec_wide[VALUE_W-1:0];
          end
        end
      end
    end
  end

endmodule

// ===== rtl/aipr_check.sv =====
// Final check of a finished number: sign handling, signed or unsigned range compare.
// Depends on aipr_pkg.
module aipr_check (
  input  aipr_pkg::parse_summary_t      sum,
  input  logic [aipr_pkg::VALUE_W-1:0]  min_value,
  input  logic [aipr_pkg::VALUE_W-1:0]  max_value,
  output logic [aipr_pkg::VALUE_W-1:0]  number,
  output logic                          status
);
  import aipr_pkg::*;

  logic [VALUE_W-1:0] neg_val;
  logic [VALUE_W-1:0] val;
  logic               err;

  assign neg_val = '0 - sum.acc;

  always_comb begin
    err = sum.failed || !sum.has_digits;
    val = sum.acc;
    if (sum.mode == MODE_SDEC) begin
      if (sum.neg) begin
        if (sum.acc > SIGN_BIT) begin
          err = 1'b1;
        end
        val = neg_val;
      end else if (sum.acc[VALUE_W-1]) begin
        err = 1'b1;
      end
      if ($signed(val) < $signed(min_value) || $signed(val) > $signed(max_value)) begin
        err = 1'b1;
      end
    end else begin
      // A minus sign taken in signed mode and finished in another mode is an error.
      if (sum.neg || val < min_value || val > max_value) begin
        err = 1'b1;
      end
    end
    number = err ? '0 : val;
    status = err;
  end

endmodule

// ===== tb/sv/tb_top.sv =====
// Self-checking testbench of the ASCII integer parser with range check.
// Drives characters and register writes, predicts every parsed number in a scoreboard class.
// Depends on aipr_pkg, the interfaces in aipr_ifs and the top level of the block.
module tb_top;
  import aipr_pkg::*;

  localparam int SETTLE_CYCLES = 8;
  localparam int HOLD_CYCLES = 300;
  localparam int PHASE_CHARS = 240;

  typedef struct {
    logic [VALUE_W-1:0] number;
    logic               status;
  } parsed_number_t;

  class number_scoreboard;
    logic [1:0]         cur_mode;
    logic [VALUE_W-1:0] lo_bound;
    logic [VALUE_W-1:0] hi_bound;
    logic [COUNT_W-1:0] len_cap;

    logic [VALUE_W-1:0] acc;
    logic [COUNT_W-1:0] digits;
    logic               minus_seen;
    logic               broken;
    logic               first_pending;

    parsed_number_t parsed_numbers[$];
    int failures;

    function new();
      cur_mode = MODE_UDEC;
      lo_bound = '0;
      hi_bound = '1;
      len_cap = LENGTH_RESET;
      failures = 0;
      clear_number();
    endfunction

    function void clear_number();
      acc = '0;
      digits = '0;
      minus_seen = 1'b0;
      broken = 1'b0;
      first_pending = 1'b1;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [VALUE_W-1:0] data);
      case (idx)
        REG_MODE: cur_mode = data[1:0];
        REG_MIN_VALUE: lo_bound = data;
        REG_MAX_VALUE: hi_bound = data;
        REG_MAX_LENGTH: len_cap = data[COUNT_W-1:0];
        default: ;
      endcase
    endfunction

    // Advances the parse by one accepted character and, on the final one, queues the result.
    function void note_char(logic [CHAR_W-1:0] c, logic last);
      logic [1:0]         m;
      logic               hex;
      logic               first;
      logic               is_digit;
      logic [3:0]         dv;
      logic [COUNT_W-1:0] cap;
      logic               bad;
      logic [VALUE_W-1:0] val;
      parsed_number_t     r;
      m = (cur_mode == MODE_SPARE) ? MODE_UDEC : cur_mode;
      hex = (m == MODE_HEX);
      first = first_pending;
      first_pending = 1'b0;
      if (!broken) begin
        if (first && m == MODE_SDEC && c == CHAR_MINUS) begin
          minus_seen = 1'b1;
        end else begin
          is_digit = 1'b1;
          dv = 4'd0;
          if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
            dv = 4'(c - CHAR_ZERO);
          end else if (hex && c >= CHAR_LOWER_A && c <= CHAR_LOWER_F) begin
            dv = 4'(c - CHAR_LOWER_A + 8'd10);
          end else if (hex && c >= CHAR_UPPER_A && c <= CHAR_UPPER_F) begin
            dv = 4'(c - CHAR_UPPER_A + 8'd10);
          end else begin
            is_digit = 1'b0;
          end
          if (!is_digit) begin
            broken = 1'b1;
          end else begin
            cap = (hex && len_cap > HEX_CAP) ? HEX_CAP : len_cap;
            if (digits != COUNT_MAX) digits = digits + 1'b1;
            if (digits > cap) begin
              broken = 1'b1;
            end else if (hex) begin
              if (acc[VALUE_W-1 -: 4] != 4'd0) broken = 1'b1;
              else acc = {acc[VALUE_W-5:0], dv};
            end else if (acc > ({VALUE_W{1'b1}} - 64'(dv)) / 64'd10) begin
              broken = 1'b1;
            end else begin
              acc = acc * 64'd10 + 64'(dv);
            end
          end
        end
      end
      if (last) begin
        bad = broken || digits == '0;
        val = acc;
        if (!bad) begin
          if (m == MODE_SDEC) begin
            if (minus_seen) begin
              if (val > SIGN_BIT) bad = 1'b1;
              else val = -val;
            end else if (val >= SIGN_BIT) begin
              bad = 1'b1;
            end
            if (!bad && ($signed(val) < $signed(lo_bound) || $signed(val) > $signed(hi_bound)))
              bad = 1'b1;
          end else if (minus_seen || val < lo_bound || val > hi_bound) begin
            bad = 1'b1;
          end
        end
        r.number = bad ? '0 : val;
        r.status = bad;
        parsed_numbers.push_back(r);
        clear_number();
      end
    endfunction

    function void check_number(logic [VALUE_W-1:0] number, logic status);
      parsed_number_t e;
      if (parsed_numbers.size() == 0) begin
        failures++;
        if (failures <= 10)
          $display("unexpected result: number %h status %b", number, status);
      end else begin
        e = parsed_numbers.pop_front();
        if (e.number !== number || e.status !== status) begin
          failures++;
          if (failures <= 10)
            $display("mismatch: expected number %h status %b, got number %h status %b",
                     e.number, e.status, number, status);
        end
      end
    endfunction
  endclass

  logic clk;
  logic rst;

  aipr_char_if   chars_if();
  aipr_result_if result_if();
  aipr_cfg_if    cfg_if();

  ascii_integer_parser_range_check_unit u_top (
    .clk(clk),
    .rst(rst),
    .chars(chars_if),
    .result(result_if),
    .cfg(cfg_if)
  );

  number_scoreboard sb = new();

  int tx_idle = 25;
  int rx_idle = 25;
  bit hold_request = 1'b0;
  int hold_left = 0;

  logic [CHAR_W-1:0] text_q[$];

  string corner_text[12] = '{
    "18446744073709551615", "18446744073709551616", "99999999999999999999",
    "9223372036854775807", "9223372036854775808", "-9223372036854775808",
    "-9223372036854775809", "ffffffffffffffff", "FFFFFFFFFFFFFFFF",
    "10000000000000000", "00000000000000000000", "-0"
  };

  initial clk = 1'b0;
  always #10 clk = ~clk;

  always @(posedge clk) begin
    if (!rst && chars_if.valid && chars_if.ready)
      sb.note_char(chars_if.char_code, chars_if.last_char);
  end

  always @(posedge clk) begin
    if (!rst && result_if.valid && result_if.ready)
      sb.check_number(result_if.number, result_if.status);
  end

  // Result side: random back-pressure, plus one long hold-off on request.
  initial begin
    result_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        hold_left = HOLD_CYCLES;
        hold_request = 1'b0;
      end
      if (hold_left != 0) begin
        hold_left--;
        result_if.ready <= 1'b0;
      end else begin
        result_if.ready <= ($urandom_range(99) >= rx_idle);
      end
    end
  end

  // Entered and left at a falling edge; valid stays high when no gap follows.
  task automatic send_char(logic [CHAR_W-1:0] c, logic last);
    while ($urandom_range(99) < tx_idle) begin
      chars_if.valid <= 1'b0;
      @(negedge clk);
    end
    chars_if.valid <= 1'b1;
    chars_if.char_code <= c;
    chars_if.last_char <= last;
    @(posedge clk);
    while (!chars_if.ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_queue();
    for (int i = 0; i < text_q.size(); i++)
      send_char(text_q[i], i == text_q.size() - 1);
  endtask

  function automatic void load_text(string s);
    text_q.delete();
    for (int i = 0; i < s.len(); i++) text_q.push_back(s[i]);
  endfunction

  task automatic send_text(string s);
    load_text(s);
    send_queue();
  endtask

  // Waits until every parsed number has come out and the pipeline has emptied.
  task automatic wait_quiet();
    chars_if.valid <= 1'b0;
    while (sb.parsed_numbers.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [VALUE_W-1:0] data, bit lower);
    cfg_if.valid <= 1'b1;
    cfg_if.reg_index <= idx;
    cfg_if.data <= data;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    sb.set_reg(idx, data);
    @(negedge clk);
    if (lower) cfg_if.valid <= 1'b0;
  endtask

  function automatic logic [CHAR_W-1:0] random_digit(logic hex);
    int r;
    if (!hex) return CHAR_ZERO + 8'($urandom_range(9));
    r = $urandom_range(21);
    if (r < 10) return CHAR_ZERO + 8'(r);
    if (r < 16) return CHAR_LOWER_A + 8'(r - 10);
    return CHAR_UPPER_A + 8'(r - 16);
  endfunction

  // Mostly well-formed numbers for the current mode, with corner strings and noise mixed in.
  function automatic void build_number(logic [1:0] m);
    int kind;
    int len;
    kind = $urandom_range(99);
    text_q.delete();
    if (kind < 8) begin
      load_text(corner_text[$urandom_range(11)]);
    end else if (kind < 16) begin
      len = $urandom_range(1, 5);
      repeat (len) text_q.push_back(8'($urandom_range(255)));
    end else begin
      if (m == MODE_SDEC && $urandom_range(3) == 0) text_q.push_back(CHAR_MINUS);
      else if (m != MODE_SDEC && $urandom_range(49) == 0) text_q.push_back(CHAR_MINUS);
      len = ($urandom_range(9) == 0) ? $urandom_range(0, 21) : $urandom_range(1, 4);
      repeat (len) text_q.push_back(random_digit(m == MODE_HEX));
      if (text_q.size() != 0 && $urandom_range(9) == 0)
        text_q.insert($urandom_range(text_q.size() - 1), 8'($urandom_range(255)));
      if (text_q.size() == 0) text_q.push_back(8'($urandom_range(255)));
    end
  endfunction

  task automatic run_phase(logic [1:0] m, logic [VALUE_W-1:0] lo, logic [VALUE_W-1:0] hi,
                           logic [COUNT_W-1:0] cap, int tx, int rx, bit hold);
    int sent;
    logic [1:0] pm;
    wait_quiet();
    write_reg(REG_MODE, 64'(m), 1'b0);
    write_reg(REG_MIN_VALUE, lo, 1'b0);
    write_reg(REG_MAX_VALUE, hi, 1'b0);
    write_reg(REG_MAX_LENGTH, 64'(cap), 1'b1);
    tx_idle = tx;
    rx_idle = rx;
    if (hold) hold_request = 1'b1;
    pm = (m == MODE_SPARE) ? MODE_UDEC : m;
    sent = 0;
    while (sent < PHASE_CHARS) begin
      build_number(pm);
      sent += text_q.size();
      send_queue();
    end
  endtask

  initial begin
    rst = 1'b1;
    chars_if.valid = 1'b0;
    chars_if.char_code = '0;
    chars_if.last_char = 1'b0;
    cfg_if.valid = 1'b0;
    cfg_if.reg_index = REG_MODE;
    cfg_if.data = '0;
    repeat (8) @(negedge clk);
    rst <= 1'b0;

    // Directed part, starting from the reset settings.
    send_text("0");
    send_text("x");
    send_text("x5");
    wait_quiet();
    write_reg(REG_MODE, 64'(MODE_SDEC), 1'b1);
    send_text("-");
    send_text("-7");
    send_text("5-");
    wait_quiet();
    write_reg(REG_MODE, 64'(MODE_HEX), 1'b1);
    send_text("fF");
    send_text("A9");
    send_text("g");
    // Mode switched between characters of one number: hex digit, then a decimal one.
    send_char(CHAR_LOWER_A, 1'b0);
    wait_quiet();
    write_reg(REG_MODE, 64'(MODE_UDEC), 1'b1);
    send_char("1", 1'b1);
    // A minus taken in signed mode, finished in unsigned mode.
    wait_quiet();
    write_reg(REG_MODE, 64'(MODE_SDEC), 1'b1);
    send_char(CHAR_MINUS, 1'b0);
    wait_quiet();
    write_reg(REG_MODE, 64'(MODE_UDEC), 1'b1);
    send_char("5", 1'b1);
    wait_quiet();
    write_reg(REG_MODE, 64'(MODE_SPARE), 1'b1);
    send_text("7");
    wait_quiet();
    write_reg(REG_MAX_LENGTH, 64'd1, 1'b1);
    send_text("12");
    send_text("3");
    wait_quiet();
    write_reg(REG_MAX_LENGTH, 64'd0, 1'b1);
    send_text("5");

    // Random part, one phase per setting.
    run_phase(MODE_UDEC, '0, '1, LENGTH_RESET, 25, 25, 1'b0);
    run_phase(MODE_SDEC, SIGN_BIT, ~SIGN_BIT, LENGTH_RESET, 25, 25, 1'b0);
    run_phase(MODE_HEX, '0, '1, COUNT_MAX, 25, 25, 1'b0);
    run_phase(MODE_UDEC, 64'($urandom_range(50)), 64'($urandom_range(50, 5000)),
              5'($urandom_range(1, 6)), 0, 0, 1'b0);
    run_phase(MODE_SDEC, 64'd0 - 64'($urandom_range(500)), 64'($urandom_range(500)),
              5'd4, 25, 25, 1'b1);
    run_phase(MODE_HEX, 64'($urandom_range(256)), 64'($urandom_range(256, 65535)),
              5'($urandom_range(1, 16)), 25, 25, 1'b0);
    run_phase(MODE_SPARE, 64'($urandom_range(100)), {$urandom, $urandom},
              5'($urandom_range(31)), 25, 25, 1'b0);
    run_phase(2'($urandom_range(3)), {$urandom, $urandom} >> $urandom_range(63),
              {VALUE_W{1'b1}} >> $urandom_range(40), 5'($urandom_range(31)), 25, 25, 1'b0);

    wait_quiet();
    if (sb.failures == 0 && sb.parsed_numbers.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
